// ===== hw/rtl/fifo_handoff_mutex_assert.svh =====
// Assertion macros shared by the mutex RTL; all checks use clk and rst_n.
`ifndef FIFO_HANDOFF_MUTEX_ASSERT_SVH
`define FIFO_HANDOFF_MUTEX_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define FHM_CHECK(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define FHM_CHECK_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fhm_pkg.sv =====
// Package with the types, codes and defaults of the FIFO handoff mutex.
package fhm_pkg;

    // Width of the task id and status fields on the ports.
    localparam int ID_FIELD_W = 8;
    localparam int STATUS_W   = 3;

    // Defaults for the top level parameters.
    localparam int DEF_TASK_ID_BITS = 8;
    localparam int DEF_WAIT_DEPTH   = 16;

    // Request kinds.
    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 3'd0,
        ST_QUEUED     = 3'd1,
        ST_RECURSIVE  = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_NOT_OWNER  = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } status_t;

    // Commands from the mutex control to the wait queue.
    typedef struct packed {
        logic push;
        logic pop;
    } q_ctrl_t;

    // Wait queue status seen by the mutex control.
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

// ===== hw/rtl/fhm_req_if.sv =====
// Request channel interface: one lock or unlock word per handshake.
interface fhm_req_if
    import fhm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [ID_FIELD_W-1:0] task_id;

    modport source (output valid, output op, output task_id, input ready);
    modport sink   (input valid, input op, input task_id, output ready);
endinterface

// ===== hw/rtl/fhm_res_if.sv =====
// Result channel interface: one result word per request.
interface fhm_res_if
    import fhm_pkg::*;
();
    logic                  valid;
    logic                  ready;
    status_t               status;
    logic                  handoff_valid;
    logic [ID_FIELD_W-1:0] resumed_task;
    logic                  held_after;
    logic [ID_FIELD_W-1:0] holder_after;

    modport source (output valid, output status, output handoff_valid,
                    output resumed_task, output held_after, output holder_after,
                    input ready);
    modport sink   (input valid, input status, input handoff_valid,
                    input resumed_task, input held_after, input holder_after,
                    output ready);
endinterface

// ===== hw/rtl/fhm_wait_q.sv =====
// Wait queue of task ids with a prefetched head entry.
module fhm_wait_q
    import fhm_pkg::*;
#(
    parameter int DEPTH   = DEF_WAIT_DEPTH,
    parameter int ID_BITS = DEF_TASK_ID_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  q_ctrl_t            ctrl,
    input  logic [ID_BITS-1:0] push_id,
    output q_stat_t            stat,
    output logic [ID_BITS-1:0] head_id
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [ID_BITS-1:0] mem [DEPTH];
    logic [AW-1:0]      head_reg;
    logic [AW-1:0]      head_next;
    logic [AW-1:0]      tail_reg;
    logic [AW-1:0]      tail_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [ID_BITS-1:0] head_data_reg;

    // Status flags from the fill count.
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign head_id    = head_data_reg;

    // Pointer and count update, wrapping at the last entry.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (ctrl.push)
        begin
            tail_next  = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage write and registered read of the next head entry.
    // A push into an empty queue lands on the entry that is read next.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_id;
        end
        if (ctrl.push && (tail_reg == head_next))
        begin
            head_data_reg <= push_id;
        end
        else
        begin
            head_data_reg <= mem[head_next];
        end
    end

endmodule

// ===== hw/rtl/fifo_handoff_mutex.sv =====
// Top level of the FIFO handoff mutex: lock control, wait queue and result register.
// Results: a result word is valid in the cycle after its request word is accepted.
// Throughput: one request per cycle while no result is stalled, set by the holder update and the
// wait queue, which keeps its oldest entry prefetched in a register.
// Reset: mutex free, holder 0, wait queue empty, no result pending; the queue
// storage itself is not cleared and is only used after it was written.
`include "fifo_handoff_mutex_assert.svh"

module fifo_handoff_mutex
    import fhm_pkg::*;
#(
    parameter int TASK_ID_BITS = DEF_TASK_ID_BITS,
    parameter int WAIT_DEPTH   = DEF_WAIT_DEPTH
) (
    input  logic     clk,
    input  logic     rst_n,
    fhm_req_if.sink   req,
    fhm_res_if.source res
);

    logic                    accept;
    logic [TASK_ID_BITS-1:0] req_id;
    q_ctrl_t                 q_ctrl;
    q_stat_t                 q_stat;
    logic [TASK_ID_BITS-1:0] q_head_id;

    logic                    held_reg;
    logic                    held_next;
    logic [TASK_ID_BITS-1:0] holder_reg;
    logic [TASK_ID_BITS-1:0] holder_next;

    status_t                 status_next;
    logic                    handoff_next;
    logic [TASK_ID_BITS-1:0] resumed_next;

    logic                    res_valid_reg;
    status_t                 res_status_reg;
    logic                    res_handoff_reg;
    logic [ID_FIELD_W-1:0]   res_resumed_reg;
    logic                    res_held_reg;
    logic [ID_FIELD_W-1:0]   res_holder_reg;

    // A new request is taken whenever the result register is free or drains.
    assign req.ready = !res_valid_reg || res.ready;
    assign accept    = req.valid && req.ready;
    assign req_id    = TASK_ID_BITS'(req.task_id);

    // Lock and unlock decision.
    always_comb
    begin
        status_next  = ST_NOT_OWNER;
        handoff_next = 1'b0;
        resumed_next = '0;
        held_next    = held_reg;
        holder_next  = holder_reg;
        q_ctrl.push  = 1'b0;
        q_ctrl.pop   = 1'b0;
        if (req.op == OP_LOCK)
        begin
            priority if (!held_reg)
            begin
                status_next = ST_GRANTED;
                held_next   = 1'b1;
                holder_next = req_id;
            end
            else if (holder_reg == req_id)
            begin
                status_next = ST_RECURSIVE;
            end
            else if (q_stat.full)
            begin
                status_next = ST_QUEUE_FULL;
            end
            else
            begin
                status_next = ST_QUEUED;
                q_ctrl.push = accept;
            end
        end
        else
        begin
            priority if (!held_reg || (holder_reg != req_id))
            begin
                status_next = ST_NOT_OWNER;
            end
            else if (!q_stat.empty)
            begin
                status_next  = ST_RELEASED;
                handoff_next = 1'b1;
                resumed_next = q_head_id;
                holder_next  = q_head_id;
                q_ctrl.pop   = accept;
            end
            else
            begin
                status_next = ST_RELEASED;
                held_next   = 1'b0;
                holder_next = '0;
            end
        end
    end

    fhm_wait_q #(
        .DEPTH   (WAIT_DEPTH),
        .ID_BITS (TASK_ID_BITS)
    ) u_wait_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (q_ctrl),
        .push_id (req_id),
        .stat    (q_stat),
        .head_id (q_head_id)
    );

    // Ownership state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg   <= 1'b0;
            holder_reg <= '0;
        end
        else if (accept)
        begin
            held_reg   <= held_next;
            holder_reg <= holder_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= accept || (res_valid_reg && !res.ready);
        end
    end

    // Result payload, loaded with each accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_status_reg  <= status_next;
            res_handoff_reg <= handoff_next;
            res_resumed_reg <= ID_FIELD_W'(resumed_next);
            res_held_reg    <= held_next;
            res_holder_reg  <= held_next ? ID_FIELD_W'(holder_next) : '0;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.status        = res_status_reg;
    assign res.handoff_valid = res_handoff_reg;
    assign res.resumed_task  = res_resumed_reg;
    assign res.held_after    = res_held_reg;
    assign res.holder_after  = res_holder_reg;

    // A pending result that is stalled must block new requests.
    `FHM_CHECK(a_no_overrun,
               !(res_valid_reg && !res.ready) || !req.ready,
               "request taken over a stalled result")

    // A handoff result names the new holder.
    `FHM_CHECK(a_handoff_holder,
               !res_valid_reg || !res_handoff_reg ||
               (res_held_reg && (res_holder_reg == res_resumed_reg)),
               "handoff result does not name the holder")

    // A lock on a free mutex makes the requester the holder.
    `FHM_CHECK_NEXT(a_grant_holds,
                    accept && !held_reg && (req.op == OP_LOCK),
                    held_reg && (holder_reg == $past(req_id)) &&
                    (res_status_reg == ST_GRANTED),
                    "grant did not take ownership")

endmodule
